// ===== sv/assert_macros.svh =====
// assertion macros shared by the slot table allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every edge outside reset
`define STA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("sta assertion failed");
// antecedent implies consequent at the next edge
`define STA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sta assertion failed");
`else
`define STA_ASSERT(lbl, clk, rstn, prop)
`define STA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/sta_pkg.sv =====
// shared types and constants of the slot table allocator
package sta_pkg;

  localparam int unsigned SLOT_W = 5;
  localparam int unsigned HW_W   = 6;
  localparam int unsigned PID_W  = 31;
  localparam int unsigned ACT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FIND  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ALLOC,
    OP_FREE,
    OP_TRIM,
    OP_FIND
  } sta_op_e;

  typedef struct packed {
    sta_op_e op;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             alloc_done;
    logic             free_hit;
    logic             trim_done;
    logic             find_done;
  } dp_stat_t;

endpackage

// ===== sv/sta_datapath.sv =====
// slot table datapath: occupied bits, id memory, high-water count and result words
`include "assert_macros.svh"

module sta_datapath #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sta_pkg::dp_cmd_t              cmd_i,
  output sta_pkg::dp_stat_t             stat_o,
  input  logic [sta_pkg::ACT_W-1:0]     action_i,
  input  logic [sta_pkg::SLOT_W-1:0]    slot_index_i,
  input  logic [sta_pkg::PID_W-1:0]     pid_value_i,
  output logic                          ok_o,
  output logic [sta_pkg::SLOT_W-1:0]    result_slot_o,
  output logic [sta_pkg::HW_W-1:0]      high_water_o
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  logic [SLOTS-1:0]              occ_q;
  logic [sta_pkg::PID_W-1:0]     mem [SLOTS];
  logic [CW-1:0]                 used_q;
  logic [CW-1:0]                 idx_q;
  logic [IW-1:0]                 cmp_idx_q;
  logic                          cmp_vld_q;
  logic [sta_pkg::PID_W-1:0]     rd_q;
  logic [sta_pkg::ACT_W-1:0]     act_q;
  logic [sta_pkg::PID_W-1:0]     pid_q;
  logic [sta_pkg::SLOT_W-1:0]    fidx_q;
  logic                          res_ok_q;
  logic [IW-1:0]                 res_slot_q;
  logic                          out_ok_q;
  logic [sta_pkg::SLOT_W-1:0]    out_slot_q;
  logic [sta_pkg::HW_W-1:0]      out_hw_q;

  logic          idx_in_range;
  logic          occ_at_idx;
  logic          alloc_done;
  logic          alloc_full;
  logic [CW-1:0] top;
  logic          trim_done;
  logic [IW-1:0] fidx;
  logic          free_hit;
  logic          issue;
  logic          find_hit;
  logic          find_done;

  assign idx_in_range = idx_q < SLOTS_C;
  assign occ_at_idx   = idx_in_range ? occ_q[idx_q[IW-1:0]] : 1'b1;
  assign alloc_done   = (idx_q >= used_q) || !occ_at_idx;
  assign alloc_full   = !idx_in_range;

  assign top       = used_q - CW'(1);
  assign trim_done = (used_q == '0) || occ_q[top[IW-1:0]];

  assign fidx     = IW'(fidx_q);
  assign free_hit = (int'(fidx_q) < int'(SLOTS)) && occ_q[fidx];

  assign issue     = idx_q < used_q;
  assign find_hit  = cmp_vld_q && occ_q[cmp_idx_q] && (rd_q == pid_q);
  assign find_done = find_hit || (!cmp_vld_q && !issue);

  assign stat_o.act        = act_q;
  assign stat_o.alloc_done = alloc_done;
  assign stat_o.free_hit   = free_hit;
  assign stat_o.trim_done  = trim_done;
  assign stat_o.find_done  = find_done;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      used_q    <= '0;
      idx_q     <= '0;
      cmp_idx_q <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        sta_pkg::OP_LOAD: begin
          idx_q     <= '0;
          cmp_vld_q <= 1'b0;
        end
        sta_pkg::OP_ALLOC: begin
          if (alloc_done) begin
            if (!alloc_full) begin
              occ_q[idx_q[IW-1:0]] <= 1'b1;
              if (idx_q >= used_q) begin
                used_q <= idx_q + CW'(1);
              end
            end
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        sta_pkg::OP_FREE: begin
          if (free_hit) begin
            occ_q[fidx] <= 1'b0;
          end
        end
        sta_pkg::OP_TRIM: begin
          if (!trim_done) begin
            used_q <= top;
          end
        end
        sta_pkg::OP_FIND: begin
          if (issue) begin
            idx_q     <= idx_q + CW'(1);
            cmp_idx_q <= idx_q[IW-1:0];
            cmp_vld_q <= 1'b1;
          end else begin
            cmp_vld_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // id memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sta_pkg::OP_ALLOC && alloc_done && !alloc_full) begin
      mem[idx_q[IW-1:0]] <= pid_q;
    end
    if (cmd_i.op == sta_pkg::OP_FIND && issue) begin
      rd_q <= mem[idx_q[IW-1:0]];
    end
  end

  // input capture and result words
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sta_pkg::OP_LOAD: begin
        act_q      <= action_i;
        pid_q      <= pid_value_i;
        fidx_q     <= slot_index_i;
        res_ok_q   <= 1'b0;
        res_slot_q <= '0;
      end
      sta_pkg::OP_ALLOC: begin
        if (alloc_done && !alloc_full) begin
          res_ok_q   <= 1'b1;
          res_slot_q <= idx_q[IW-1:0];
        end
      end
      sta_pkg::OP_FREE: begin
        if (free_hit) begin
          res_ok_q   <= 1'b1;
          res_slot_q <= fidx;
        end
      end
      sta_pkg::OP_FIND: begin
        if (find_hit) begin
          res_ok_q   <= 1'b1;
          res_slot_q <= cmp_idx_q;
        end
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_ok_q   <= res_ok_q;
      out_slot_q <= sta_pkg::SLOT_W'(res_slot_q);
      out_hw_q   <= sta_pkg::HW_W'(used_q);
    end
  end

  assign ok_o          = out_ok_q;
  assign result_slot_o = out_slot_q;
  assign high_water_o  = out_hw_q;

  `STA_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= SLOTS_C)
  `STA_ASSERT(a_mark_on_occupied, clk_i, rst_ni,
              !cmd_i.out_load || used_q == '0 || occ_q[top[IW-1:0]])
  `STA_ASSERT(a_slot_below_mark, clk_i, rst_ni,
              !(cmd_i.out_load && res_ok_q && act_q != sta_pkg::ACT_FREE) ||
              CW'(res_slot_q) < used_q)

endmodule

// ===== sv/sta_ctrl.sv =====
// slot table controller state machine and output word valid
`include "assert_macros.svh"

module sta_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sta_pkg::dp_cmd_t  cmd_o,
  input  sta_pkg::dp_stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC,
    S_FREE,
    S_TRIM,
    S_FIND,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q;
  logic   out_load;
  logic   in_accept;

  assign in_stall_o  = state_q != S_IDLE;
  assign in_accept   = in_valid_i && state_q == S_IDLE;
  assign out_load    = state_q == S_FINISH && (!out_vld_q || !out_stall_i);
  assign out_valid_o = out_vld_q;

  always_comb begin
    cmd_o.op       = sta_pkg::OP_NONE;
    cmd_o.out_load = out_load;
    state_d        = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = sta_pkg::OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.act)
          sta_pkg::ACT_ALLOC: state_d = S_ALLOC;
          sta_pkg::ACT_FREE:  state_d = S_FREE;
          sta_pkg::ACT_FIND:  state_d = S_FIND;
          default:            state_d = S_FINISH;
        endcase
      end
      S_ALLOC: begin
        cmd_o.op = sta_pkg::OP_ALLOC;
        if (stat_i.alloc_done) state_d = S_FINISH;
      end
      S_FREE: begin
        cmd_o.op = sta_pkg::OP_FREE;
        state_d  = stat_i.free_hit ? S_TRIM : S_FINISH;
      end
      S_TRIM: begin
        cmd_o.op = sta_pkg::OP_TRIM;
        if (stat_i.trim_done) state_d = S_FINISH;
      end
      S_FIND: begin
        cmd_o.op = sta_pkg::OP_FIND;
        if (stat_i.find_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  `STA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, in_stall_o)
  `STA_ASSERT_NEXT(a_out_drains, clk_i, rst_ni,
                   out_vld_q && !out_stall_i && !out_load, !out_valid_o)

endmodule

// ===== sv/slot_table_allocator_core.sv =====
// top level of the slot table allocator: controller plus datapath
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+-----------------------
//   input   | action_i slot_index_i pid_value_i        | in_valid_i / in_stall_o
//   output  | ok_o result_slot_o high_water_o          | out_valid_o / out_stall_i
//
// one word at a time; accept, dispatch, then the operation, then the finish state
// allocate scans one occupied bit a cycle, from slot 0 up to the first free slot or the mark
// find reads one id memory entry a cycle and compares it in the cycle after the read
// free clears the slot on a hit; a hit then trims the mark down past each trailing empty slot
// reset clears occupied bits and the mark at once, no clearing pass
// a result word waits in the output register; the next word is taken meanwhile
module slot_table_allocator_core #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [sta_pkg::ACT_W-1:0]  action_i,
  input  logic [sta_pkg::SLOT_W-1:0] slot_index_i,
  input  logic [sta_pkg::PID_W-1:0]  pid_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic [sta_pkg::SLOT_W-1:0] result_slot_o,
  output logic [sta_pkg::HW_W-1:0]   high_water_o
);

  sta_pkg::dp_cmd_t  cmd;
  sta_pkg::dp_stat_t stat;

  sta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  sta_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .slot_index_i  (slot_index_i),
    .pid_value_i   (pid_value_i),
    .ok_o          (ok_o),
    .result_slot_o (result_slot_o),
    .high_water_o  (high_water_o)
  );

endmodule
